// ===== src/lbcw_pkg.sv =====
// shared types, codes and helpers for the linked block chain walker
package lbcw_pkg;

    localparam int BLOCK_W           = 24;
    localparam int LEN_W             = 24;
    localparam int FILE_W            = 16;
    localparam int INDEX_W           = 8;
    localparam int PART_W            = 16;
    localparam int COUNT_W           = 10;
    localparam int BLOCK_PAYLOAD_DEF = 512;

    typedef enum logic [2:0] {
        ST_FETCH    = 3'd0,
        ST_DONE     = 3'd1,
        ST_BAD      = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_SHORT    = 3'd4,
        ST_IGNORED  = 3'd5
    } status_t;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_HEADER = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [FILE_W-1:0]    file_id;
        logic [INDEX_W-1:0]   index_num;
        logic [LEN_W-1:0]     length;
        logic [BLOCK_W-1:0]   start_block;
        logic [FILE_W-1:0]    hdr_file_id;
        logic [PART_W-1:0]    hdr_part;
        logic [BLOCK_W-1:0]   hdr_next;
        logic [INDEX_W-1:0]   hdr_cache_id;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic                 copy_enable;
        logic [BLOCK_W-1:0]   copy_block;
        logic [LEN_W-1:0]     copy_offset;
        logic [COUNT_W-1:0]   copy_count;
        logic [BLOCK_W-1:0]   fetch_block;
    } out_item_t;

    // valid block numbers: 0 < b < block_count
    function automatic logic block_ok(input logic [BLOCK_W-1:0] b,
                                      input logic [BLOCK_W-1:0] cnt);
        return (b != '0) && (b < cnt);
    endfunction

endpackage

// ===== src/lbcw_in_reg.sv =====
// input register stage holding one accepted beat
module lbcw_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lbcw_pkg::in_item_t  in_item,
    input  logic                advance,
    output logic                item_valid,
    output lbcw_pkg::in_item_t  item
);
    import lbcw_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/lbcw_step.sv =====
// walk state and the per-beat header check, start handling and copy command
module lbcw_step #(
    parameter int BLOCK_PAYLOAD = lbcw_pkg::BLOCK_PAYLOAD_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lbcw_pkg::BLOCK_W-1:0]      block_count,
    input  logic                              advance,
    input  lbcw_pkg::in_item_t                item,
    output lbcw_pkg::out_item_t               res
);
    import lbcw_pkg::*;

    localparam logic [LEN_W-1:0] PAYLOAD_LEN = LEN_W'(BLOCK_PAYLOAD);

    logic                active_reg, active_next;
    logic [BLOCK_W-1:0]  current_block_reg, current_block_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [LEN_W-1:0]    write_offset_reg, write_offset_next;
    logic [PART_W-1:0]   part_number_reg, part_number_next;
    logic [FILE_W-1:0]   want_file_reg, want_file_next;
    logic [INDEX_W-1:0]  want_index_reg, want_index_next;

    logic [LEN_W-1:0]    chunk;
    logic [LEN_W-1:0]    left_after;
    logic                hdr_match;

    assign chunk      = (remaining_reg > PAYLOAD_LEN) ? PAYLOAD_LEN : remaining_reg;
    assign left_after = remaining_reg - chunk;
    // index id 255 expects cache id 256, which never matches
    assign hdr_match  = (item.hdr_file_id == want_file_reg)
                     && (item.hdr_part == part_number_reg)
                     && ({1'b0, item.hdr_cache_id} == ({1'b0, want_index_reg} + 9'd1));

    always_comb
    begin
        active_next        = active_reg;
        current_block_next = current_block_reg;
        remaining_next     = remaining_reg;
        write_offset_next  = write_offset_reg;
        part_number_next   = part_number_reg;
        want_file_next     = want_file_reg;
        want_index_next    = want_index_reg;
        res                = '0;
        res.status         = ST_IGNORED;

        if (item.kind == KIND_START)
        begin
            want_file_next     = item.file_id;
            want_index_next    = item.index_num;
            remaining_next     = item.length;
            current_block_next = item.start_block;
            write_offset_next  = '0;
            part_number_next   = '0;
            active_next        = 1'b0;
            if (item.start_block == '0)
            begin
                res.status = (item.length != '0) ? ST_SHORT : ST_DONE;
            end
            else if (!block_ok(item.start_block, block_count))
            begin
                res.status = ST_BAD;
            end
            else
            begin
                res.status      = ST_FETCH;
                res.fetch_block = item.start_block;
                active_next     = 1'b1;
            end
        end
        else if (active_reg)
        begin
            if (!hdr_match)
            begin
                res.status  = ST_MISMATCH;
                active_next = 1'b0;
            end
            else
            begin
                res.copy_enable    = 1'b1;
                res.copy_block     = current_block_reg;
                res.copy_offset    = write_offset_reg;
                res.copy_count     = chunk[COUNT_W-1:0];
                write_offset_next  = write_offset_reg + chunk;
                remaining_next     = left_after;
                part_number_next   = part_number_reg + PART_W'(1);
                current_block_next = item.hdr_next;
                if (item.hdr_next == '0)
                begin
                    res.status  = (left_after != '0) ? ST_SHORT : ST_DONE;
                    active_next = 1'b0;
                end
                else if (!block_ok(item.hdr_next, block_count))
                begin
                    res.status  = ST_BAD;
                    active_next = 1'b0;
                end
                else
                begin
                    res.status      = ST_FETCH;
                    res.fetch_block = item.hdr_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            current_block_reg <= '0;
            remaining_reg     <= '0;
            write_offset_reg  <= '0;
            part_number_reg   <= '0;
            want_file_reg     <= '0;
            want_index_reg    <= '0;
        end
        else if (advance)
        begin
            active_reg        <= active_next;
            current_block_reg <= current_block_next;
            remaining_reg     <= remaining_next;
            write_offset_reg  <= write_offset_next;
            part_number_reg   <= part_number_next;
            want_file_reg     <= want_file_next;
            want_index_reg    <= want_index_next;
        end
    end

    a_copy_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !res.copy_enable) |->
        (res.copy_block == '0 && res.copy_offset == '0 && res.copy_count == '0))
        else $error("copy fields set without copy enable");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.status == ST_FETCH) |->
        (res.fetch_block != '0 && res.fetch_block < block_count))
        else $error("fetch of a block outside the store");

    a_fetch_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.status == ST_FETCH) |=> active_reg)
        else $error("walk not active after a fetch");

    a_end_stops_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res.status == ST_DONE || res.status == ST_BAD
                  || res.status == ST_MISMATCH || res.status == ST_SHORT)) |=> !active_reg)
        else $error("walk still active after an end status");

    a_copy_only_on_header: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.copy_enable) |-> (item.kind == KIND_HEADER))
        else $error("copy issued for a start beat");

endmodule

// ===== src/lbcw_out_reg.sv =====
// result register feeding the master side
module lbcw_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  lbcw_pkg::out_item_t  res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lbcw_pkg::out_item_t  out_item
);
    import lbcw_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t res_reg;

    assign valid_next = advance ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = res_reg;

endmodule

// ===== src/linked_block_chain_walker.sv =====
// Chain walker top level: takes one start or header beat per clock, unless held by the master
// side, and returns one result beat per input beat, in order. An accepted beat passes through the
// input register and then the result register to the master side; with the master side ready,
// one beat per cycle flows through indefinitely. The single check-and-update step between the
// two registers also updates the walk state. block_count is an exclusive upper bound:
// valid block numbers are 1 to block_count-1. Write block_count only while no beat is in flight.
module linked_block_chain_walker #(
    parameter int BLOCK_PAYLOAD = lbcw_pkg::BLOCK_PAYLOAD_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lbcw_pkg::BLOCK_W-1:0]      cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // file_id, index_num, length, start_block, hdr_file_id, hdr_part, hdr_next, hdr_cache_id
    input  logic [135:0]                      s_axis_tdata,
    // kind
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // copy_enable, copy_block, copy_offset, copy_count, fetch_block, zero pad
    output logic [87:0]                       m_axis_tdata,
    // status
    output logic [2:0]                        m_axis_tuser
);
    import lbcw_pkg::*;

    logic [BLOCK_W-1:0] block_count_reg;
    in_item_t           s_item;
    in_item_t           cur_item;
    logic               cur_valid;
    logic               advance;
    logic               out_valid;
    out_item_t          step_res;
    out_item_t          out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            block_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        s_item              = '0;
        s_item.kind         = kind_t'(s_axis_tuser);
        s_item.file_id      = s_axis_tdata[15:0];
        s_item.index_num    = s_axis_tdata[23:16];
        s_item.length       = s_axis_tdata[47:24];
        s_item.start_block  = s_axis_tdata[71:48];
        s_item.hdr_file_id  = s_axis_tdata[87:72];
        s_item.hdr_part     = s_axis_tdata[103:88];
        s_item.hdr_next     = s_axis_tdata[127:104];
        s_item.hdr_cache_id = s_axis_tdata[135:128];
    end

    // step the item when the result register is free or draining this cycle
    assign advance = cur_valid && (!out_valid || m_axis_tready);

    lbcw_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (s_item),
        .advance    (advance),
        .item_valid (cur_valid),
        .item       (cur_item)
    );

    lbcw_step #(
        .BLOCK_PAYLOAD (BLOCK_PAYLOAD)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_count (block_count_reg),
        .advance     (advance),
        .item        (cur_item),
        .res         (step_res)
    );

    lbcw_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res       (step_res),
        .out_valid (out_valid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_item.status;
    assign m_axis_tdata  = {5'b0, out_item.fetch_block, out_item.copy_count,
                            out_item.copy_offset, out_item.copy_block, out_item.copy_enable};

endmodule
